// ----- rtl/resistor_ladder_keypad_decoder_defines.svh -----
// Assertion macros shared by the keypad decoder RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef RESISTOR_LADDER_KEYPAD_DECODER_DEFINES_SVH
`define RESISTOR_LADDER_KEYPAD_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define RLKD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define RLKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define RLKD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RLKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/rlkd_pkg.sv -----
`default_nettype none

package rlkd_pkg;

    // Sample and key widths.
    localparam int SAMPLE_BITS = 10;
    localparam int MAX_KEYS    = 16;
    localparam int KEY_BITS    = 4;
    localparam int KCNT_BITS   = 5;
    localparam int BIN_BITS    = SAMPLE_BITS + 1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_COUNT       = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE_TICKS  = 3'd1;
    localparam logic [2:0] CFG_PRESS_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_WAIT_RELEASE    = 3'd3;

    // Bin size 1024 / k for a clamped key count k of 1 to 16; entry 0 mirrors k = 1.
    localparam logic [BIN_BITS-1:0] BIN_TABLE [0:MAX_KEYS] = '{
        11'd1024, 11'd1024, 11'd512, 11'd341, 11'd256, 11'd204, 11'd170, 11'd146,
        11'd128,  11'd113,  11'd102, 11'd93,  11'd85,  11'd78,  11'd73,  11'd68,
        11'd64
    };

endpackage

`default_nettype wire

// ----- rtl/rlkd_div.sv -----
`default_nettype none

// Restoring divider: one quotient bit per cycle.
module rlkd_div
    import rlkd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [SAMPLE_BITS-1:0] i_dividend,
    input  wire logic [BIN_BITS-1:0]    i_divisor,
    output logic                        o_done,
    output logic [SAMPLE_BITS-1:0]      o_quot
);

    localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

    logic [CNT_BITS-1:0]    r_cnt;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [BIN_BITS-1:0]    r_dvs;
    logic [SAMPLE_BITS-1:0] r_quo;
    logic                   r_done;

    logic [BIN_BITS-1:0]    w_trial;
    logic                   w_fit;

    // Shift the next dividend bit into the partial remainder and test it.
    // The remainder stays below the divisor, so it fits in SAMPLE_BITS bits.
    assign w_trial = {r_rem, r_quo[SAMPLE_BITS-1]};
    assign w_fit   = (w_trial >= r_dvs);

    // Step counter, remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_BITS'(SAMPLE_BITS);
                r_rem <= '0;
                r_dvs <= i_divisor;
                r_quo <= i_dividend;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                r_rem <= w_fit ? SAMPLE_BITS'(w_trial - r_dvs) : w_trial[SAMPLE_BITS-1:0];
                r_quo <= {r_quo[SAMPLE_BITS-2:0], w_fit};
                if (r_cnt == CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ----- rtl/resistor_ladder_keypad_decoder.sv -----
`default_nettype none
`include "resistor_ladder_keypad_decoder_defines.svh"

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-------------------------------------
// s        | in        | i_s_tvalid/o_s_tready | tdata[9:0] adc_sample
// m        | out       | o_m_tvalid/i_m_tready | tdata[3:0] key_index, tuser bounce_error
// cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each item is accepted, then divided in the shared restoring divider (one quotient
// bit per cycle); the finished quotient is then passed on and the press state is
// updated.
// An item that produces a result holds in the final step while the output register is full.
// The input is not ready while an item is being worked on; configuration is always ready.
// Reset is synchronous and active low; it restores register defaults and the idle phase.
module resistor_ladder_keypad_decoder
    import rlkd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [9:0] adc_sample, [15:10] zero
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [3:0] key_index, [7:4] zero
    output logic             o_m_tuser,   // [0] bounce_error
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} t_state;
    typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_WAIT} t_phase;

    localparam logic [SAMPLE_BITS-1:0] TICK_MAX = '1;

    // Configuration registers.
    logic [KCNT_BITS-1:0]   r_key_count;
    logic [SAMPLE_BITS-1:0] r_debounce;
    logic [SAMPLE_BITS-1:0] r_threshold;
    logic                   r_wait_rel;

    // Sequencer and press state.
    t_state                 r_state;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [SAMPLE_BITS-1:0] r_tick;
    logic [SAMPLE_BITS-1:0] n_tick;
    logic [KEY_BITS-1:0]    r_first;
    logic [KEY_BITS-1:0]    n_first;
    logic                   r_held;
    logic                   n_held;
    logic                   r_released;

    logic                   w_accept;
    logic [KCNT_BITS-1:0]   w_kc;
    logic [KCNT_BITS-1:0]   w_kmax5;
    logic [KEY_BITS-1:0]    w_kmax;
    logic                   w_div_done;
    logic [SAMPLE_BITS-1:0] w_quot;
    logic [KEY_BITS-1:0]    w_key;
    logic                   w_emit;
    logic [KEY_BITS-1:0]    w_emit_key;
    logic                   w_emit_err;
    logic                   w_fire;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Key count clamped into 1..MAX_KEYS.
    always_comb begin
        if (r_key_count == '0) begin
            w_kc = KCNT_BITS'(1);
        end else if (r_key_count > KCNT_BITS'(MAX_KEYS)) begin
            w_kc = KCNT_BITS'(MAX_KEYS);
        end else begin
            w_kc = r_key_count;
        end
    end

    assign w_kmax5 = w_kc - KCNT_BITS'(1);
    assign w_kmax  = w_kmax5[KEY_BITS-1:0];

    // Shared divider: sample divided by the bin size of the current key count.
    rlkd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_divisor  (BIN_TABLE[w_kc]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Saturate the quotient to the highest key.
    assign w_key = (w_quot > SAMPLE_BITS'(w_kmax5)) ? w_kmax : w_quot[KEY_BITS-1:0];

    // Press state update for the item in the final step.
    always_comb begin
        logic                v_confirm;
        logic                v_err;
        logic [KEY_BITS-1:0] v_fk;
        v_confirm  = 1'b0;
        v_err      = 1'b0;
        v_fk       = r_first;
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_first    = r_first;
        n_held     = r_held;
        w_emit     = 1'b0;
        w_emit_key = '0;
        w_emit_err = 1'b0;
        unique case (r_phase)
            PH_WAIT: begin
                if (r_released) begin
                    n_phase    = PH_IDLE;
                    w_emit     = 1'b1;
                    w_emit_err = r_held;
                    w_emit_key = r_held ? '0 : r_first;
                end
            end
            PH_DEBOUNCE: begin
                n_tick = (r_tick < TICK_MAX) ? (r_tick + SAMPLE_BITS'(1)) : r_tick;
                if (n_tick >= r_debounce) begin
                    v_confirm = 1'b1;
                end
            end
            default: begin
                if (!r_released) begin
                    v_fk    = w_key;
                    n_first = w_key;
                    n_held  = 1'b0;
                    n_tick  = '0;
                    if (r_debounce != '0) begin
                        n_phase = PH_DEBOUNCE;
                    end else begin
                        v_confirm = 1'b1;
                    end
                end
            end
        endcase
        // Confirming sample: compare with the key taken at press start.
        if (v_confirm) begin
            v_err = (w_key != v_fk);
            if (r_wait_rel && !r_released) begin
                n_held  = v_err;
                n_first = v_err ? '0 : v_fk;
                n_phase = PH_WAIT;
            end else begin
                n_phase    = PH_IDLE;
                w_emit     = 1'b1;
                w_emit_err = v_err;
                w_emit_key = v_err ? '0 : v_fk;
            end
        end
    end

    // The final step completes unless its result meets a full output register.
    assign w_fire = !w_emit || !o_m_tvalid || i_m_tready;

    // Sequencer, press state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_first     <= '0;
            r_held      <= 1'b0;
            r_key_count <= KCNT_BITS'(16);
            r_debounce  <= SAMPLE_BITS'(50);
            r_threshold <= SAMPLE_BITS'(1000);
            r_wait_rel  <= 1'b0;
            o_m_tvalid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_COUNT:       r_key_count <= i_cfg_data[KCNT_BITS-1:0];
                    CFG_DEBOUNCE_TICKS:  r_debounce  <= i_cfg_data;
                    CFG_PRESS_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_WAIT_RELEASE:    r_wait_rel  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Output valid: set by a result from the final step, cleared when taken.
            if ((r_state == ST_FIN) && w_fire && w_emit) begin
                o_m_tvalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_released <= (i_s_tdata[SAMPLE_BITS-1:0] >= r_threshold);
                        r_state    <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fire) begin
                        r_phase <= n_phase;
                        r_tick  <= n_tick;
                        r_first <= n_first;
                        r_held  <= n_held;
                        r_state <= ST_IDLE;
                        if (w_emit) begin
                            o_m_tdata  <= {4'b0000, w_emit_key};
                            o_m_tuser  <= w_emit_err;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // A bounce error always comes with key zero.
    `RLKD_ASSERT_SAME(a_err_key_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == 8'd0)
    // The divider finishes only while the sequencer waits for it.
    `RLKD_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV)
    // Once an item is taken the input stays closed in the next cycle.
    `RLKD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_tready)
    // A result is loaded only from the final step.
    `RLKD_ASSERT_NEXT(a_load_from_fin, i_clk, i_rst_n, !o_m_tvalid && r_state != ST_FIN,
        !o_m_tvalid)

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rlkd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;

    // One decoded key report as it leaves the block.
    typedef struct packed {
        logic [3:0] key;
        logic       err;
    } key_report_t;

    typedef enum logic [1:0] {
        PRESS_IDLE,
        PRESS_DEBOUNCE,
        PRESS_HOLD
    } press_phase_e;

    // Tracks the keypad press state and the reports still owed by the block.
    class keypad_scoreboard;
        logic [4:0]   key_count;
        logic [9:0]   debounce_ticks;
        logic [9:0]   press_threshold;
        logic         wait_release;
        press_phase_e phase;
        logic [9:0]   tick_count;
        logic [3:0]   first_key;
        logic         held_error;
        key_report_t  reports_due[$];
        int           errors;

        function new();
            key_count       = 5'd16;
            debounce_ticks  = 10'd50;
            press_threshold = 10'd1000;
            wait_release    = 1'b0;
            phase           = PRESS_IDLE;
            tick_count      = '0;
            first_key       = '0;
            held_error      = 1'b0;
            errors          = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [9:0] val);
            case (idx)
                CFG_KEY_COUNT:       key_count       = val[4:0];
                CFG_DEBOUNCE_TICKS:  debounce_ticks  = val;
                CFG_PRESS_THRESHOLD: press_threshold = val;
                CFG_WAIT_RELEASE:    wait_release    = val[0];
                default: ;
            endcase
        endfunction

        // Bin index of a sample on the ladder, saturated to the top key.
        function logic [3:0] key_of(logic [9:0] sample);
            int k;
            int bin;
            int q;
            k = key_count;
            if (k == 0) k = 1;
            if (k > MAX_KEYS) k = MAX_KEYS;
            bin = (1 << SAMPLE_BITS) / k;
            q = int'(sample) / bin;
            if (q > k - 1) q = k - 1;
            return q[3:0];
        endfunction

        // A bounce error always reports key zero.
        function void owe_report(logic [3:0] key, logic err);
            key_report_t r;
            r.key = err ? 4'd0 : key;
            r.err = err;
            reports_due.push_back(r);
        endfunction

        // Advances the press state by one tick and notes any report it causes.
        function void note_sample(logic [9:0] sample);
            logic       released;
            logic [3:0] key;
            logic       mismatch;
            released = (sample >= press_threshold);
            if (phase == PRESS_HOLD) begin
                if (released) begin
                    phase = PRESS_IDLE;
                    owe_report(first_key, held_error);
                end
                return;
            end
            if (phase == PRESS_DEBOUNCE) begin
                if (tick_count < 10'd1023) tick_count = tick_count + 10'd1;
                if (tick_count < debounce_ticks) return;
            end else begin
                if (released) return;
                first_key  = key_of(sample);
                held_error = 1'b0;
                tick_count = '0;
                if (debounce_ticks != 0) begin
                    phase = PRESS_DEBOUNCE;
                    return;
                end
            end
            // Confirming tick.
            key = key_of(sample);
            mismatch = (key != first_key);
            if (wait_release && !released) begin
                held_error = mismatch;
                if (mismatch) first_key = 4'd0;
                phase = PRESS_HOLD;
                return;
            end
            phase = PRESS_IDLE;
            owe_report(first_key, mismatch);
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_report(logic [7:0] tdata, logic tuser);
            key_report_t want;
            if (reports_due.size() == 0) begin
                report($sformatf("report key %0d error %0b with none owed", tdata[3:0], tuser));
                return;
            end
            want = reports_due.pop_front();
            if (tdata[3:0] !== want.key)
                report($sformatf("key_index got %0d want %0d", tdata[3:0], want.key));
            if (tdata[7:4] !== 4'd0)
                report($sformatf("tdata padding got %h", tdata[7:4]));
            if (tuser !== want.err)
                report($sformatf("bounce_error got %0b want %0b", tuser, want.err));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;
    wire         m_tuser;
    wire         cfg_ready;

    keypad_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left  = 1;
    int hold_reqs   = 0;
    int hold_served = 0;
    int hold_left   = 0;

    resistor_ladder_keypad_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cycle count and run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: a long hold-off on request, otherwise a stall pattern that rotates.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_reqs) begin
            m_tready    <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end else begin
            case (cycle_count[8:7])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= cycle_count[2];
            endcase
        end
    end

    // Every accepted report is checked against the oldest one owed.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_report(m_tdata, m_tuser);
    end

    // Offers one sample, then may close the burst with a gap.
    task automatic push_sample(input logic [9:0] sample);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, sample};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_sample(sample);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops sending and waits until every owed report has come and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int kc, input int db, input int th, input int wr);
        settle();
        write_reg(CFG_KEY_COUNT, 10'(kc));
        write_reg(CFG_DEBOUNCE_TICKS, 10'(db));
        write_reg(CFG_PRESS_THRESHOLD, 10'(th));
        write_reg(CFG_WAIT_RELEASE, 10'(wr));
    endtask

    // Mostly well-formed presses with jitter and bounces, the rest random noise.
    task automatic run_presses(input int n, input int db, input int th);
        int done;
        int base;
        int len;
        int pick;
        int s;
        done = 0;
        while (done < n) begin
            if (th != 0 && $urandom_range(0, 9) < 7) begin
                base = $urandom_range(0, th - 1);
                len  = 1 + ((db > 40) ? 40 : db) + $urandom_range(0, 2);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 7);
                    s = base;
                    if (pick == 0) s = $urandom_range(0, th - 1);
                    else if (pick < 3 && base + 2 < th) s = base + $urandom_range(0, 2);
                    push_sample(10'(s));
                    done++;
                end
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    push_sample(10'($urandom_range(th, 1023)));
                    done++;
                end
            end else begin
                push_sample(10'($urandom_range(0, 1023)));
                done++;
            end
        end
    endtask

    initial begin
        int kc;
        int db;
        int th;
        int wr;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: released samples, a press at the top key, then one tick in.
        push_sample(10'd1023);
        push_sample(10'd1000);
        push_sample(10'd999);
        push_sample(10'd0);

        // Key count zero acts as one key; zero debounce confirms on the press tick.
        configure(0, 0, 1023, 0);
        push_sample(10'd0);
        push_sample(10'd1022);
        push_sample(10'd1023);

        // Key count beyond the maximum, wait for release: match, bounce, and
        // a sample already released at the confirming tick.
        configure(31, 1, 1023, 1);
        push_sample(10'd10);
        push_sample(10'd10);
        push_sample(10'd1023);
        push_sample(10'd1000);
        push_sample(10'd100);
        push_sample(10'd1023);
        push_sample(10'd5);
        push_sample(10'd1023);

        // Longest debounce; the press is left open across the next change.
        configure(16, 1023, 1023, 0);
        push_sample(10'd300);
        push_sample(10'd300);
        push_sample(10'd300);

        // A shorter debounce confirms the open press; threshold zero never presses.
        configure(3, 2, 0, 0);
        push_sample(10'd0);
        push_sample(10'd1023);

        // Three keys: samples near the top of the range map to the last key.
        configure(3, 0, 1023, 0);
        push_sample(10'd1021);
        push_sample(10'd682);

        // Random settings per phase.
        for (int p = 0; p < 10; p++) begin
            kc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0, 1, 2: db = 0;
                3:       db = $urandom_range(7, 30);
                default: db = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 7))
                0:       th = 0;
                1:       th = 1023;
                default: th = $urandom_range(100, 1023);
            endcase
            wr = $urandom_range(0, 1);
            configure(kc, db, th, wr);
            run_presses(100, db, th);
        end

        // Back-pressure: the receiver holds off while the sender keeps offering.
        configure(8, 1, 800, 0);
        hold_reqs <= hold_reqs + 1;
        burst_left = 1000;
        run_presses(40, 1, 800);
        burst_left = 1;
        settle();

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- resistor_ladder_keypad_decoder.f -----
+incdir+rtl
rtl/rlkd_pkg.sv
rtl/rlkd_div.sv
rtl/resistor_ladder_keypad_decoder.sv
test/tb_top.sv
